/* design/lspr_pkg.sv */
// ----------------------------------------------------------------------------
// lspr_pkg
// Shared widths, codes and types of the looped sample playback resampler.
// ----------------------------------------------------------------------------
package lspr_pkg;

  localparam int OP_W       = 2;
  localparam int ADDR_W     = 14;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 18;
  localparam int COUNT_W    = 15;
  localparam int INDEX_W    = 15;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  // A stereo fetch address is twice a 15-bit index plus one.
  localparam int FETCH_W    = 17;
  // Largest value that the position output can show.
  localparam int POS_MAX    = 16383;

  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK_ENABLE = 3'd4;

  typedef struct packed {
    logic [STEP_W-1:0]  step_ratio;
    logic [COUNT_W-1:0] frame_count;
    logic               stereo_mode;
    logic               loop_enable;
    logic               playback_enable;
  } cfg_t;

  // Everything the output stage needs to know about one frame besides the
  // words read from the store.
  typedef struct packed {
    logic             silent;
    logic             wrap;
    logic             ended;
    logic [POS_W-1:0] position;
    logic             stereo;
    logic             odd;
    logic             left_ok;
    logic             right_ok;
  } frame_meta_t;

endpackage

/* design/looped_sample_playback_resampler.sv */
// ----------------------------------------------------------------------------
// looped_sample_playback_resampler
// Plays 16-bit samples from a local store at a 2.16 fixed-point step, mono
// or stereo, looping or stopping at the frame count.
//
//   Channel  Direction  Handshake              Payload
//   in       into       in_valid / in_stall    opcode, word_address, word_value
//   out      out of     out_valid / out_stall  left_sample, right_sample,
//                                              frame_position, wrapped, ended
//   cfg      into       cfg_write_enable       cfg_index, cfg_data
//
// One item is taken per cycle when in_stall is low. A frame item steps the
// phase and reads both store banks at its transfer edge; its words are
// registered in the read stage, then in the output register. The banks hold
// even and odd words, so a stereo pair is one access. Reset clears the
// phase, the ended flag and the pipeline but not the store. A stalled output
// holds its result; the input stalls only while a frame waits behind it.
// ----------------------------------------------------------------------------
module looped_sample_playback_resampler import lspr_pkg::*; #(
  parameter int STORE_WORDS = 16384
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OP_W-1:0]            opcode,
  input  logic [ADDR_W-1:0]          word_address,
  input  logic signed [SAMPLE_W-1:0] word_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] left_sample,
  output logic signed [SAMPLE_W-1:0] right_sample,
  output logic [POS_W-1:0]           frame_position,
  output logic                       wrapped,
  output logic                       ended
);

  localparam logic [FETCH_W-1:0] STORE_LIM = FETCH_W'(STORE_WORDS);

  cfg_t               cfg;
  logic               accept;
  logic               frame_go;
  logic               restart_go;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_index;
  logic [INDEX_W-1:0] rd_index;
  frame_meta_t        meta;
  logic signed [SAMPLE_W-1:0] rd_even;
  logic signed [SAMPLE_W-1:0] rd_odd;
  logic               hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_ratio      <= STEP_W'(65536);
      cfg.frame_count     <= '0;
      cfg.stereo_mode     <= 1'b0;
      cfg.loop_enable     <= 1'b1;
      cfg.playback_enable <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_STEP_RATIO:      cfg.step_ratio      <= cfg_data[STEP_W-1:0];
        CFG_FRAME_COUNT:     cfg.frame_count     <= cfg_data[COUNT_W-1:0];
        CFG_STEREO_MODE:     cfg.stereo_mode     <= cfg_data[0];
        CFG_LOOP_ENABLE:     cfg.loop_enable     <= cfg_data[0];
        CFG_PLAYBACK_ENABLE: cfg.playback_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_stall   = hold;
    accept     = in_valid && !in_stall;
    frame_go   = accept && (opcode == OP_FRAME);
    restart_go = accept && (opcode == OP_RESTART);
    // Writes beyond the store are dropped.
    wr_en      = accept && (opcode == OP_WRITE) &&
                 ({{(FETCH_W - ADDR_W){1'b0}}, word_address} < STORE_LIM);
    wr_index   = INDEX_W'(word_address >> 1);
  end

  lspr_phase #(
    .STORE_WORDS(STORE_WORDS)
  ) u_phase (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .frame_go   (frame_go),
    .restart_go (restart_go),
    .meta       (meta),
    .rd_index   (rd_index)
  );

  lspr_store #(
    .STORE_WORDS(STORE_WORDS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_odd   (word_address[0]),
    .wr_index (wr_index),
    .wr_data  (word_value),
    .rd_en    (frame_go),
    .rd_index (rd_index),
    .rd_even  (rd_even),
    .rd_odd   (rd_odd)
  );

  lspr_out u_out (
    .clk            (clk),
    .rst            (rst),
    .launch         (frame_go),
    .meta_in        (meta),
    .rd_even        (rd_even),
    .rd_odd         (rd_odd),
    .hold           (hold),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .frame_position (frame_position),
    .wrapped        (wrapped),
    .ended          (ended)
  );

endmodule

/* design/lspr_store.sv */
// ----------------------------------------------------------------------------
// lspr_store
// Sample store split into an even and an odd bank, one write and one
// registered read per bank and cycle.
// ----------------------------------------------------------------------------
module lspr_store import lspr_pkg::*; #(
  parameter int STORE_WORDS = 16384
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic                       wr_odd,
  input  logic [INDEX_W-1:0]         wr_index,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [INDEX_W-1:0]         rd_index,
  output logic signed [SAMPLE_W-1:0] rd_even,
  output logic signed [SAMPLE_W-1:0] rd_odd
);

  localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  logic signed [SAMPLE_W-1:0] mem_even [BANK_DEPTH];
  logic signed [SAMPLE_W-1:0] mem_odd  [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_odd) begin
      mem_even[wr_index[BANK_AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_even <= mem_even[rd_index[BANK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_odd) begin
      mem_odd[wr_index[BANK_AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_odd <= mem_odd[rd_index[BANK_AW-1:0]];
    end
  end

endmodule

/* design/lspr_phase.sv */
// ----------------------------------------------------------------------------
// lspr_phase
// Phase accumulator: steps the read index and fraction for each frame,
// handles wrap and end of playback, and forms the store read request.
// ----------------------------------------------------------------------------
module lspr_phase import lspr_pkg::*; #(
  parameter int STORE_WORDS = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               frame_go,
  input  logic               restart_go,
  output frame_meta_t        meta,
  output logic [INDEX_W-1:0] rd_index
);

  localparam int POS_LIM_I = (STORE_WORDS - 1 < POS_MAX) ? STORE_WORDS - 1 : POS_MAX;
  localparam logic [INDEX_W:0]   POS_LIM   = (INDEX_W + 1)'(POS_LIM_I);
  localparam logic [FETCH_W-1:0] STORE_LIM = FETCH_W'(STORE_WORDS);

  logic [INDEX_W-1:0] read_index;
  logic [FRAC_W-1:0]  phase_fraction;
  logic               end_reached;

  logic [FRAC_W+2:0]  sum;
  logic [INDEX_W:0]   stepped;
  logic               at_end;
  logic               active;
  logic               ending;
  logic               playing;
  logic [INDEX_W-1:0] play_index;
  logic [INDEX_W:0]   pos;
  logic [FETCH_W-1:0] left_addr;
  logic [FETCH_W-1:0] right_addr;
  logic               left_ok;

  always_comb begin
    sum        = {3'b000, phase_fraction} + {1'b0, cfg.step_ratio};
    stepped    = {1'b0, read_index} + (INDEX_W + 1)'(sum[FRAC_W+2:FRAC_W]);
    at_end     = stepped >= {1'b0, cfg.frame_count};
    active     = cfg.playback_enable && !end_reached;
    ending     = active && at_end && !cfg.loop_enable;
    playing    = active && !(at_end && !cfg.loop_enable);
    // A wrap always lands on index zero; any overshoot is dropped.
    play_index = at_end ? '0 : stepped[INDEX_W-1:0];

    priority if (ending) begin
      pos = stepped;
    end else if (playing) begin
      pos = {1'b0, play_index};
    end else begin
      pos = {1'b0, read_index};
    end

    left_addr  = cfg.stereo_mode ? {1'b0, play_index, 1'b0} : {2'b00, play_index};
    right_addr = {1'b0, play_index, 1'b1};
    left_ok    = left_addr < STORE_LIM;

    meta.silent   = !playing;
    meta.wrap     = playing && at_end;
    meta.ended    = end_reached || ending;
    meta.position = (pos > POS_LIM) ? POS_LIM[POS_W-1:0] : pos[POS_W-1:0];
    meta.stereo   = cfg.stereo_mode;
    meta.odd      = play_index[0];
    meta.left_ok  = left_ok;
    meta.right_ok = cfg.stereo_mode ? (right_addr < STORE_LIM) : left_ok;

    // Stereo pairs sit at the same row of both banks; a mono word sits at
    // half its address in the bank its low bit picks.
    rd_index = cfg.stereo_mode ? play_index : (play_index >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index     <= '0;
      phase_fraction <= '0;
      end_reached    <= 1'b0;
    end else if (restart_go) begin
      read_index     <= '0;
      phase_fraction <= '0;
      end_reached    <= 1'b0;
    end else if (frame_go) begin
      if (playing) begin
        read_index     <= play_index;
        phase_fraction <= sum[FRAC_W-1:0];
      end
      if (ending) begin
        end_reached <= 1'b1;
      end
    end
  end

  a_wrap_to_zero: assert property (@(posedge clk) disable iff (rst)
    frame_go && meta.wrap |=> read_index == '0)
    else $error("wrapping frame did not return the read index to zero");

  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    end_reached && !restart_go |=> end_reached)
    else $error("ended flag cleared without a restart");

  a_silent_holds_phase: assert property (@(posedge clk) disable iff (rst)
    frame_go && meta.silent |=> $stable(read_index) && $stable(phase_fraction))
    else $error("silent frame moved the read phase");

endmodule

/* design/lspr_out.sv */
// ----------------------------------------------------------------------------
// lspr_out
// Read stage and output register: picks the store words for each frame,
// forces silence where needed and holds the result until it is taken.
// ----------------------------------------------------------------------------
module lspr_out import lspr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       launch,
  input  frame_meta_t                meta_in,
  input  logic signed [SAMPLE_W-1:0] rd_even,
  input  logic signed [SAMPLE_W-1:0] rd_odd,
  output logic                       hold,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] left_sample,
  output logic signed [SAMPLE_W-1:0] right_sample,
  output logic [POS_W-1:0]           frame_position,
  output logic                       wrapped,
  output logic                       ended
);

  logic                       read_valid;
  frame_meta_t                read_meta;
  logic                       advance;
  logic signed [SAMPLE_W-1:0] left_word;
  logic signed [SAMPLE_W-1:0] right_word;

  always_comb begin
    advance = read_valid && (!out_valid || !out_stall);
    hold    = read_valid && !advance;

    if (read_meta.stereo) begin
      left_word  = rd_even;
      right_word = rd_odd;
    end else begin
      left_word  = read_meta.odd ? rd_odd : rd_even;
      right_word = left_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      read_valid <= launch || (read_valid && !advance);
      out_valid  <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      read_meta <= meta_in;
    end
    if (advance) begin
      left_sample    <= (read_meta.silent || !read_meta.left_ok)  ? '0 : left_word;
      right_sample   <= (read_meta.silent || !read_meta.right_ok) ? '0 : right_word;
      frame_position <= read_meta.position;
      wrapped        <= read_meta.wrap;
      ended          <= read_meta.ended;
    end
  end

  a_no_launch_on_hold: assert property (@(posedge clk) disable iff (rst)
    hold |-> !launch)
    else $error("new frame launched while the read stage was blocked");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("frame left the read stage but no result appeared");

endmodule
